### hw/rtl/bphr_pkg.sv
package bphr_pkg;

	localparam int LEVEL_BITS      = 14;
	localparam int TICK_W          = 64;
	localparam int KIND_W          = 2;
	localparam int ID_W            = 4;
	localparam int NUM_BUTTONS_DEF = 14;

	localparam logic [TICK_W-1:0] HOLD_THR_RST = 64'd9600000;

	localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HOLD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// per-button record kept in RAM
	typedef struct packed {
		logic              hold_rep;
		logic              pressed;
		logic [TICK_W-1:0] start;
	} btn_entry_t;

	// scan stage to event stage
	typedef struct packed {
		logic              busy;      // a button result is on offer
		logic              has_ev;    // that button produced an event
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic              frame_end; // final button of the frame
	} bphr_req_t;

endpackage

### hw/rtl/bphr_frame_if.sv
interface bphr_frame_if import bphr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] button_levels;
	logic [TICK_W-1:0]     now_tick;

	modport source (output valid, button_levels, now_tick, input ready);
	modport sink   (input valid, button_levels, now_tick, output ready);
endinterface

### hw/rtl/bphr_event_if.sv
interface bphr_event_if import bphr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [ID_W-1:0]   button_id;
	logic              last_event;

	modport source (output valid, event_kind, button_id, last_event, input ready);
	modport sink   (input valid, event_kind, button_id, last_event, output ready);
endinterface

### hw/rtl/bphr_ram.sv
module bphr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/bphr_scan.sv
module bphr_scan import bphr_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
	localparam int IW         = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata,
	bphr_frame_if.sink        frame,
	output bphr_req_t         req,
	input  logic              ev_rdy
);

	typedef enum logic {S_IDLE, S_SCAN} scan_state_t;

	scan_state_t            state_q;
	logic [IW-1:0]          idx_q;
	logic [NUM_BUTTONS-1:0] lv_q;
	logic [TICK_W-1:0]      now_q;
	logic [TICK_W-1:0]      thr_q;
	logic [NUM_BUTTONS-1:0] vld_q;
	logic                   v_s1;
	logic [IW-1:0]          idx_s1;
	logic                   end_s1;

	logic                   adv;
	logic                   issue;
	logic                   wr;
	logic                   accept;
	logic                   pressed;
	logic [TICK_W-1:0]      held;
	btn_entry_t             rd_raw;
	btn_entry_t             cur;
	btn_entry_t             nxt;

	assign adv    = !v_s1 || ev_rdy;
	assign issue  = (state_q == S_SCAN) && adv;
	assign wr     = v_s1 && ev_rdy;
	assign accept = frame.valid && frame.ready;

	assign frame.ready = (state_q == S_IDLE) && !v_s1;

	bphr_ram #(
		.WIDTH($bits(btn_entry_t)),
		.DEPTH(NUM_BUTTONS)
	) u_ram (
		.clk  (clk),
		.we   (wr),
		.waddr(idx_s1),
		.wdata(nxt),
		.re   (issue),
		.raddr(idx_q),
		.rdata(rd_raw)
	);

	// never-written entries read as cleared
	always_comb begin
		cur     = vld_q[idx_s1] ? rd_raw : '0;
		pressed = lv_q[idx_s1];
		held    = now_q - cur.start;
		nxt     = cur;
		nxt.pressed = pressed;
		req.busy      = v_s1;
		req.has_ev    = 1'b0;
		req.kind      = KIND_PRESS;
		req.id        = ID_W'(idx_s1);
		req.frame_end = end_s1;
		if (pressed && !cur.pressed) begin
			nxt.start  = now_q;
			req.has_ev = 1'b1;
			req.kind   = KIND_PRESS;
		end else if (pressed && cur.pressed) begin
			if ((held > thr_q) && !cur.hold_rep) begin
				nxt.hold_rep = 1'b1;
				req.has_ev   = 1'b1;
				req.kind     = KIND_HOLD;
			end
		end else if (!pressed && cur.pressed) begin
			nxt.hold_rep = 1'b0;
			req.has_ev   = 1'b1;
			req.kind     = KIND_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			thr_q   <= HOLD_THR_RST;
			vld_q   <= '0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
			end_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (wr) begin
				vld_q[idx_s1] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (adv) begin
						v_s1 <= 1'b0;
					end
					if (accept) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (adv) begin
						v_s1   <= 1'b1;
						idx_s1 <= idx_q;
						end_s1 <= (idx_q == IW'(NUM_BUTTONS - 1));
						if (idx_q == IW'(NUM_BUTTONS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// frame payload
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= frame.now_tick;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				lv_q[i] <= (i < LEVEL_BITS) ? frame.button_levels[i % LEVEL_BITS] : 1'b0;
			end
		end
	end

endmodule

### hw/rtl/bphr_evout.sv
module bphr_evout import bphr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bphr_req_t  req,
	output logic       ev_rdy,
	bphr_event_if.source evt
);

	logic              p_v_q;
	logic [KIND_W-1:0] p_kind_q;
	logic [ID_W-1:0]   p_id_q;
	logic              flush_q;
	logic              o_v_q;
	logic [KIND_W-1:0] o_kind_q;
	logic [ID_W-1:0]   o_id_q;
	logic              o_last_q;

	logic              o_free;
	logic              take;
	logic              o_load;

	// one event held back until we know whether it closes the frame
	assign o_free = !o_v_q || evt.ready;
	assign ev_rdy = !flush_q && (!p_v_q || o_free);
	assign take   = req.busy && ev_rdy;
	assign o_load = flush_q ? (p_v_q && o_free) : (take && req.has_ev && p_v_q);

	assign evt.valid      = o_v_q;
	assign evt.event_kind = o_kind_q;
	assign evt.button_id  = o_id_q;
	assign evt.last_event = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_v_q   <= 1'b0;
			flush_q <= 1'b0;
			o_v_q   <= 1'b0;
		end else begin
			if (o_load) begin
				o_v_q <= 1'b1;
			end else if (evt.ready) begin
				o_v_q <= 1'b0;
			end
			if (flush_q) begin
				if (!p_v_q) begin
					flush_q <= 1'b0;
				end else if (o_free) begin
					o_kind_q <= p_kind_q;
					o_id_q   <= p_id_q;
					o_last_q <= 1'b1;
					p_v_q    <= 1'b0;
					flush_q  <= 1'b0;
				end
			end else if (take) begin
				if (req.has_ev) begin
					if (p_v_q) begin
						o_kind_q <= p_kind_q;
						o_id_q   <= p_id_q;
						o_last_q <= 1'b0;
					end
					p_v_q    <= 1'b1;
					p_kind_q <= req.kind;
					p_id_q   <= req.id;
				end
				if (req.frame_end) begin
					flush_q <= 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/button_press_hold_release_detector.sv
// Channel  Dir  Beat contents
// frame    in   button_levels[13:0], now_tick[63:0]
// evt      out  event_kind[1:0], button_id[3:0], last_event
// cfg      in   cfg_we, cfg_wdata[63:0] (hold_threshold)
//
// With no back-pressure a frame is scanned as one RAM read per button in
// index order, followed by a step that closes the frame.
// Reset clears the sequencer, event stage and entry valid bits and loads
// the threshold with HOLD_THR_RST; the button RAM itself is not swept.
// A stall on evt freezes the scan; the next frame is taken once the last
// button has been written back, while its events may still be draining.
module button_press_hold_release_detector import bphr_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata,
	bphr_frame_if.sink        frame,
	bphr_event_if.source      evt
);

	bphr_req_t req;
	logic      ev_rdy;

	// read-modify-write scan over the per-button RAM
	bphr_scan #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.frame    (frame),
		.req      (req),
		.ev_rdy   (ev_rdy)
	);

	// holds back one event so the frame's final beat can be marked
	bphr_evout u_evout (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ev_rdy(ev_rdy),
		.evt   (evt)
	);

endmodule
